>>> sv/tagged_line_token_parser_assert.svh
// Assertion macros used by the tagged line token parser checker.
// Needs a clk_i and an active-low rst_ni in the scope that expands them.
`ifndef TAGGED_LINE_TOKEN_PARSER_ASSERT_SVH
`define TAGGED_LINE_TOKEN_PARSER_ASSERT_SVH

// Check a property on every rising edge outside reset
`define TLP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition, once seen, is followed by another in the next cycle
`define TLP_ASSERT_NEXT(label, cond, nxt, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (nxt)) \
    else $error(msg);

`endif

>>> sv/tlp_pkg.sv
// Shared types and constants of the tagged line token parser.
// No dependencies; imported by every module of the block.
package tlp_pkg;

  // Nesting depth limit: the smaller of the configured maximum and the 8-bit range
  localparam int unsigned MaxDepth   = 255;
  localparam int unsigned DepthCap   = (MaxDepth < 255) ? MaxDepth : 255;
  localparam logic [7:0]  DepthLimit = 8'(DepthCap);

  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharReturn  = 8'h0D;

  localparam int unsigned RegAddrW = 5;
  localparam int unsigned TdataW   = 24;

  typedef enum logic [1:0] {
    KIND_CONTENT  = 2'd0,
    KIND_ELEM_END = 2'd1,
    KIND_DOC_END  = 2'd2,
    KIND_ERROR    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_UNKNOWN_TAG  = 2'd0,
    ERR_UNBALANCED   = 2'd1,
    ERR_UNTERMINATED = 2'd2,
    ERR_OVERFLOW     = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    ELEM_OPEN  = 2'd0,
    ELEM_CLOSE = 2'd1,
    ELEM_ATTR  = 2'd2,
    ELEM_VALUE = 2'd3
  } elem_e;

  typedef enum logic [2:0] {
    REG_OPEN  = 3'd0,
    REG_CLOSE = 3'd1,
    REG_ATTR  = 3'd2,
    REG_VALUE = 3'd3,
    REG_CONT  = 3'd4
  } reg_e;

  typedef struct packed {
    logic [7:0] open_code;
    logic [7:0] close_code;
    logic [7:0] attr_code;
    logic [7:0] value_code;
    logic [7:0] cont_code;
  } cfg_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    elem_e      elem_type;
    err_e       error_code;
    logic [7:0] nest_depth;
    logic       last;
  } res_t;

  // Results of one byte: up to two, in order
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } step_t;

endpackage

>>> sv/tlp_cfg_regs.sv
// Configuration registers of the tagged line token parser behind an APB-style port.
// Depends on tlp_pkg.
module tlp_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tlp_pkg::RegAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output tlp_pkg::cfg_t                 cfg_o
);
  import tlp_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[RegAddrW-1:2];
  assign wr_en   = psel & penable & pwrite & pready;

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_OPEN:  cfg_d.open_code  = pwdata[7:0];
        REG_CLOSE: cfg_d.close_code = pwdata[7:0];
        REG_ATTR:  cfg_d.attr_code  = pwdata[7:0];
        REG_VALUE: cfg_d.value_code = pwdata[7:0];
        REG_CONT:  cfg_d.cont_code  = pwdata[7:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_code  <= 8'd62;
      cfg_q.close_code <= 8'd60;
      cfg_q.attr_code  <= 8'd64;
      cfg_q.value_code <= 8'd61;
      cfg_q.cont_code  <= 8'd46;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_OPEN:  prdata = {24'd0, cfg_q.open_code};
      REG_CLOSE: prdata = {24'd0, cfg_q.close_code};
      REG_ATTR:  prdata = {24'd0, cfg_q.attr_code};
      REG_VALUE: prdata = {24'd0, cfg_q.value_code};
      REG_CONT:  prdata = {24'd0, cfg_q.cont_code};
      default:   prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/tlp_parse_core.sv
// Input register and parse logic of the tagged line token parser: phase, element
// type, nesting depth and end flag, and the zero to two results of each byte.
// Depends on tlp_pkg.
module tlp_parse_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [7:0]     s_axis_tdata,   // [7:0] in_byte
  input  logic           s_axis_tlast,   // is_end
  input  tlp_pkg::cfg_t  cfg_i,
  output tlp_pkg::step_t step_o,
  output logic           step_valid_o,
  input  logic           step_ready_i
);
  import tlp_pkg::*;

  typedef enum logic [1:0] {
    PH_TAG     = 2'd0,
    PH_CONTENT = 2'd1,
    PH_EOL     = 2'd2
  } phase_e;

  phase_e     phase_q, phase_d;
  elem_e      type_q, type_d;
  logic [7:0] depth_q, depth_d;
  logic       fin_q, fin_d;

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       end_q;
  logic       take;
  logic       load;

  res_t       ee;
  logic [7:0] ee_depth;
  logic       tag_skip;
  logic       tag_hit;
  elem_e      tag_type;
  step_t      step;

  function automatic res_t make_res(kind_e k, logic [7:0] b, elem_e t, err_e e,
                                    logic [7:0] dep);
    res_t r;
    r.kind       = k;
    r.out_byte   = b;
    r.elem_type  = t;
    r.error_code = e;
    r.nest_depth = dep;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic res_t doc_res(logic [7:0] dep);
    res_t r;
    if (dep != 8'd0) begin
      r = make_res(KIND_ERROR, 8'd0, ELEM_OPEN, ERR_UNBALANCED, dep);
    end else begin
      r = make_res(KIND_DOC_END, 8'd0, ELEM_CLOSE, ERR_UNKNOWN_TAG, dep);
    end
    return r;
  endfunction

  // Input register: refill when empty or while the held byte is consumed
  assign take          = in_valid_q & step_ready_i;
  assign s_axis_tready = ~in_valid_q | take;
  assign load          = s_axis_tvalid & s_axis_tready;
  assign step_valid_o  = in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (load) begin
      in_valid_q <= 1'b1;
    end else if (take) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= s_axis_tdata;
      end_q  <= s_axis_tlast;
    end
  end

  // Element end of the element in progress, with its depth update
  always_comb begin
    ee       = make_res(KIND_ELEM_END, 8'd0, type_q, ERR_UNKNOWN_TAG, depth_q);
    ee_depth = depth_q;
    case (type_q)
      ELEM_OPEN: begin
        if (depth_q >= DepthLimit) begin
          ee = make_res(KIND_ERROR, 8'd0, ELEM_OPEN, ERR_OVERFLOW, depth_q);
        end else begin
          ee_depth      = depth_q + 8'd1;
          ee.nest_depth = ee_depth;
        end
      end
      ELEM_CLOSE: begin
        if (depth_q == 8'd0) begin
          ee = make_res(KIND_ERROR, 8'd0, ELEM_OPEN, ERR_UNBALANCED, depth_q);
        end else begin
          ee_depth      = depth_q - 8'd1;
          ee.nest_depth = ee_depth;
        end
      end
      default: ee = make_res(KIND_ELEM_END, 8'd0, type_q, ERR_UNKNOWN_TAG, depth_q);
    endcase
  end

  // Tag decode, first match wins
  always_comb begin
    tag_skip = (byte_q == CharNewline) || (byte_q == CharReturn);
    tag_hit  = 1'b1;
    tag_type = ELEM_OPEN;
    if (byte_q == cfg_i.open_code) begin
      tag_type = ELEM_OPEN;
    end else if (byte_q == cfg_i.close_code) begin
      tag_type = ELEM_CLOSE;
    end else if (byte_q == cfg_i.attr_code) begin
      tag_type = ELEM_ATTR;
    end else if (byte_q == cfg_i.value_code) begin
      tag_type = ELEM_VALUE;
    end else begin
      tag_hit = 1'b0;
    end
  end

  // Results and next state of the held byte
  always_comb begin
    step.count  = 2'd0;
    step.first  = make_res(KIND_CONTENT, 8'd0, ELEM_OPEN, ERR_UNKNOWN_TAG, depth_q);
    step.second = step.first;
    phase_d     = phase_q;
    type_d      = type_q;
    depth_d     = depth_q;
    fin_d       = fin_q;
    if (!fin_q) begin
      if (end_q) begin
        fin_d   = 1'b1;
        phase_d = PH_TAG;
        unique case (phase_q)
          PH_CONTENT: begin
            step.first = make_res(KIND_ERROR, 8'd0, ELEM_OPEN, ERR_UNTERMINATED, depth_q);
            step.count = 2'd1;
          end
          PH_EOL: begin
            step.first  = ee;
            step.second = doc_res(ee_depth);
            depth_d     = ee_depth;
            step.count  = 2'd2;
          end
          default: begin
            step.first = doc_res(depth_q);
            step.count = 2'd1;
          end
        endcase
      end else begin
        unique case (phase_q)
          PH_CONTENT: begin
            if (byte_q == CharNewline) begin
              phase_d = PH_EOL;
            end else if (byte_q != CharReturn) begin
              step.first = make_res(KIND_CONTENT, byte_q, ELEM_OPEN, ERR_UNKNOWN_TAG,
                                    depth_q);
              step.count = 2'd1;
            end
          end
          PH_EOL: begin
            if (byte_q == cfg_i.cont_code) begin
              // Embedded newline, stay in the element
              step.first = make_res(KIND_CONTENT, CharNewline, ELEM_OPEN, ERR_UNKNOWN_TAG,
                                    depth_q);
              step.count = 2'd1;
              phase_d    = PH_CONTENT;
            end else begin
              // Close the element, then treat the byte as a tag
              step.first = ee;
              step.count = 2'd1;
              depth_d    = ee_depth;
              phase_d    = PH_TAG;
              if (tag_hit && !tag_skip) begin
                type_d  = tag_type;
                phase_d = PH_CONTENT;
              end else if (!tag_skip) begin
                step.second = make_res(KIND_ERROR, 8'd0, ELEM_OPEN, ERR_UNKNOWN_TAG,
                                       ee_depth);
                step.count  = 2'd2;
              end
            end
          end
          default: begin
            phase_d = PH_TAG;
            if (tag_hit && !tag_skip) begin
              type_d  = tag_type;
              phase_d = PH_CONTENT;
            end else if (!tag_skip) begin
              step.first = make_res(KIND_ERROR, 8'd0, ELEM_OPEN, ERR_UNKNOWN_TAG, depth_q);
              step.count = 2'd1;
            end
          end
        endcase
      end
    end
    // Mark the final result of the byte
    if (step.count == 2'd1) begin
      step.first.last = 1'b1;
    end
    if (step.count == 2'd2) begin
      step.second.last = 1'b1;
    end
  end

  assign step_o = step;

  // Parser state, advanced when the held byte is consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG;
      type_q  <= ELEM_OPEN;
      depth_q <= 8'd0;
      fin_q   <= 1'b0;
    end else if (take) begin
      phase_q <= phase_d;
      type_q  <= type_d;
      depth_q <= depth_d;
      fin_q   <= fin_d;
    end
  end

endmodule

>>> sv/tlp_result_buf.sv
// Result stage of the tagged line token parser: output register and one pending
// register for the second result of a byte. Depends on tlp_pkg.
module tlp_result_buf (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tlp_pkg::step_t              step_i,
  input  logic                        step_valid_i,
  output logic                        step_ready_o,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [tlp_pkg::TdataW-1:0]  m_axis_tdata,  // out_byte, elem_type, error_code,
                                                     // nest_depth, zero fill
  output logic [1:0]                  m_axis_tuser,  // kind
  output logic                        m_axis_tlast   // last
);
  import tlp_pkg::*;

  res_t out_q, out_d;
  res_t pend_q, pend_d;
  logic out_valid_q, out_valid_d;
  logic pend_valid_q, pend_valid_d;
  logic out_free;
  logic step_take;

  assign out_free     = ~out_valid_q | m_axis_tready;
  assign step_ready_o = ~pend_valid_q & out_free;
  assign step_take    = step_valid_i & step_ready_o;

  // Drain the pending result first, else load the new step
  always_comb begin
    out_d        = out_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q & ~m_axis_tready;
    pend_valid_d = pend_valid_q;
    if (pend_valid_q && out_free) begin
      out_d        = pend_q;
      out_valid_d  = 1'b1;
      pend_valid_d = 1'b0;
    end else if (step_take && step_i.count != 2'd0) begin
      out_d       = step_i.first;
      out_valid_d = 1'b1;
      if (step_i.count == 2'd2) begin
        pend_d       = step_i.second;
        pend_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_q.nest_depth, out_q.error_code, out_q.elem_type,
                          out_q.out_byte};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;

endmodule

>>> sv/tagged_line_token_parser.sv
// Top level of the tagged line token parser.
// Depends on tlp_pkg, tlp_cfg_regs, tlp_parse_core and tlp_result_buf.

// The parser takes one byte per clock cycle while the result stage is ready. A
// byte passes an input register and is parsed from it; its first result is loaded
// into the output register once the result stage can take it. While m_axis_tready
// is high the output stage issues one result per cycle: a byte that gives two
// results (an element end followed by an unknown-tag error, the document end or an
// unbalanced error) holds the input until its second result has left the pending
// register. Bytes with no result (newlines, carriage returns, tag bytes) are
// consumed without output. After the end marker has been parsed, all further input
// is accepted and dropped until reset. The user must write configuration registers
// through the APB port only while the block is idle; the block does not enforce it.
module tagged_line_token_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] in_byte
  input  logic                          s_axis_tlast,   // is_end
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tlp_pkg::TdataW-1:0]    m_axis_tdata,   // [7:0] out_byte, [9:8] elem_type,
                                                        // [11:10] error_code,
                                                        // [19:12] nest_depth, [23:20] zero
  output logic [1:0]                    m_axis_tuser,   // [1:0] kind
  output logic                          m_axis_tlast,   // last
  // Configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tlp_pkg::RegAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import tlp_pkg::*;

  cfg_t  cfg;
  step_t step;
  logic  step_valid;
  logic  step_ready;

  tlp_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tlp_parse_core u_parse_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .cfg_i         (cfg),
    .step_o        (step),
    .step_valid_o  (step_valid),
    .step_ready_i  (step_ready)
  );

  tlp_result_buf u_result_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .step_valid_i  (step_valid),
    .step_ready_o  (step_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

>>> sv/tlp_checker.sv
// Port-level checks of the tagged line token parser, bound to the top level.
// Depends on tlp_pkg and tagged_line_token_parser_assert.svh.
`include "tagged_line_token_parser_assert.svh"

module tlp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [tlp_pkg::TdataW-1:0]   m_axis_tdata,
  input logic [1:0]                   m_axis_tuser,
  input logic                         m_axis_tlast
);
  import tlp_pkg::*;

  // Hold a stalled result
  `TLP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")

  // Document end closes the run at depth zero
  `TLP_ASSERT(a_doc_end_fields, m_axis_tvalid && m_axis_tuser == KIND_DOC_END |-> m_axis_tlast && m_axis_tdata[19:12] == 8'd0 && m_axis_tdata[9:8] == ELEM_CLOSE, "bad document end")

  // Content and error results carry no element type
  `TLP_ASSERT(a_no_type, m_axis_tvalid && (m_axis_tuser == KIND_CONTENT || m_axis_tuser == KIND_ERROR) |-> m_axis_tdata[9:8] == 2'd0, "stray element type")

  // Nothing follows a transferred document end
  `TLP_ASSERT_NEXT(a_quiet_after_end, m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_DOC_END, !m_axis_tvalid, "result after document end")

endmodule

bind tagged_line_token_parser tlp_checker u_tlp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
